// ----- hdl/fud_pkg.sv -----
// Shared types and constants for the form body field decoder.
// Holds result codes, field codes, character codes and the key tables.
// No dependencies.
package fud_pkg;

    // Result kind codes
    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_END   = 2'd2
    } res_kind_t;

    // Field codes; NO_FIELD means no value is open
    localparam logic [1:0] FIELD_SSID     = 2'd0;
    localparam logic [1:0] FIELD_PASSWORD = 2'd1;
    localparam logic [1:0] FIELD_URL      = 2'd2;
    localparam logic [1:0] NO_FIELD       = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_NAME_LEN     = 2'd0;
    localparam logic [1:0] REG_PASSWORD_LEN = 2'd1;
    localparam logic [1:0] REG_URL_LEN      = 2'd2;

    localparam int          CFG_W         = 9;
    localparam logic [8:0]  NAME_LEN_RST  = 9'd32;
    localparam logic [8:0]  PASS_LEN_RST  = 9'd64;
    localparam logic [8:0]  URL_LEN_RST   = 9'd256;

    // Escape phase codes
    localparam logic [1:0] PCT_IDLE  = 2'd0;
    localparam logic [1:0] PCT_ONE   = 2'd1;
    localparam logic [1:0] PCT_TWO   = 2'd2;

    // Character codes
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;

    // Key text, padded with zeros to 16 positions
    localparam logic [7:0] KEY_TEXT [0:2][0:15] = '{
        '{8'h73, 8'h73, 8'h69, 8'h64, 8'h3D, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h70, 8'h61, 8'h73, 8'h73, 8'h77, 8'h6F, 8'h72, 8'h64,
          8'h3D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h69, 8'h6D, 8'h61, 8'h67, 8'h65, 8'h5F, 8'h75, 8'h72,
          8'h6C, 8'h3D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KEY_LEN [0:2] = '{4'd5, 4'd9, 4'd10};

    // One queued result
    typedef struct packed {
        res_kind_t   kind;
        logic [1:0]  sel;
        logic [7:0]  data;
        logic        last;
    } result_t;

    // Hex digit: bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic logic is_white(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Byte from a two-character escape, base-16 parse rules
    function automatic logic [7:0] escape_value(input logic [7:0] c1,
                                                input logic [7:0] c2);
        logic [4:0] d1;
        logic [4:0] d2;
        logic [7:0] r;
        d1 = hex_val(c1);
        d2 = hex_val(c2);
        if (is_white(c1))
            r = d2[4] ? {4'd0, d2[3:0]} : 8'd0;
        else if (c1 == CHAR_MINUS)
            r = d2[4] ? (8'd0 - {4'd0, d2[3:0]}) : 8'd0;
        else if (!d1[4])
            r = 8'd0;
        else if (!d2[4])
            r = {4'd0, d1[3:0]};
        else
            r = {d1[3:0], d2[3:0]};
        return r;
    endfunction

endpackage

// ----- hdl/form_urlencoded_field_decoder_core.sv -----
// Top level of the form body field decoder: byte parser and result queue.
// Depends on fud_pkg.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  body    | body_valid, body_stall, body_byte, body_last | in
//  result  | res_valid, res_stall, kind, field_sel,       | out
//          | data_byte, run_last                          |
//  config  | cfg_wr_en, cfg_index, cfg_data               | in
//
// One body byte is parsed in the cycle it is accepted; its 0 to 3 results enter
// a four-entry result queue and leave one per cycle while res_stall is low, the
// first one presented the cycle after acceptance. Bytes are taken every cycle while
// the queue holds at most one entry, so the rate is one byte per cycle when each
// byte gives at most one result and res_stall is low; the queue drain rate sets it otherwise.
// Reset clears parser state, the queue and restores the length limits.
module form_urlencoded_field_decoder_core #(
    parameter int VALUE_LEN_MAX = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // body bytes
    input  logic        body_valid,
    output logic        body_stall,
    input  logic [7:0]  body_byte,
    input  logic        body_last,
    // results
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  kind,
    output logic [1:0]  field_sel,
    output logic [7:0]  data_byte,
    output logic        run_last,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int CNT_W = $clog2(VALUE_LEN_MAX + 1);
    localparam int LIM_W = (CNT_W > fud_pkg::CFG_W) ? CNT_W : fud_pkg::CFG_W;
    localparam int Q_DEPTH = 4;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    // Configuration registers
    logic [8:0]        max_len_reg [0:2];

    // Parser state
    logic [3:0]        tok_pos_reg,   tok_pos_next;
    logic [2:0]        cand_reg,      cand_next;
    logic [1:0]        act_reg,       act_next;
    logic [CNT_W-1:0]  raw_reg,       raw_next;
    logic [1:0]        pct_reg,       pct_next;
    logic [7:0]        first_reg,     first_next;
    logic              closed_reg,    closed_next;
    logic              stopped_reg,   stopped_next;

    // Result queue
    fud_pkg::result_t  q_reg [0:Q_DEPTH-1];
    logic [QP_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0]   cnt_reg;

    logic              body_acc;
    logic              res_acc;
    logic [LIM_W-1:0]  lim [0:2];
    fud_pkg::result_t  res_v [0:2];
    logic [1:0]        n_v;

    assign body_stall = (cnt_reg > QC_W'(1));
    assign body_acc   = body_valid && !body_stall;
    assign res_valid  = (cnt_reg != '0);
    assign res_acc    = res_valid && !res_stall;

    assign kind      = q_reg[rd_ptr_reg].kind;
    assign field_sel = q_reg[rd_ptr_reg].sel;
    assign data_byte = q_reg[rd_ptr_reg].data;
    assign run_last  = q_reg[rd_ptr_reg].last;

    // Effective limits, clipped to VALUE_LEN_MAX
    always_comb
    begin
        for (int f = 0; f < 3; f++)
        begin
            if (LIM_W'(max_len_reg[f]) > LIM_W'(VALUE_LEN_MAX))
                lim[f] = LIM_W'(VALUE_LEN_MAX);
            else
                lim[f] = LIM_W'(max_len_reg[f]);
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg[0] <= fud_pkg::NAME_LEN_RST;
            max_len_reg[1] <= fud_pkg::PASS_LEN_RST;
            max_len_reg[2] <= fud_pkg::URL_LEN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fud_pkg::REG_NAME_LEN:     max_len_reg[0] <= cfg_data;
                fud_pkg::REG_PASSWORD_LEN: max_len_reg[1] <= cfg_data;
                fud_pkg::REG_URL_LEN:      max_len_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Byte parser: next state and up to three results for this byte
    always_comb
    begin
        logic [7:0]        c;
        logic [7:0]        v;
        logic [LIM_W-1:0]  act_lim;
        logic              found;

        tok_pos_next = tok_pos_reg;
        cand_next    = cand_reg;
        act_next     = act_reg;
        raw_next     = raw_reg;
        pct_next     = pct_reg;
        first_next   = first_reg;
        closed_next  = closed_reg;
        stopped_next = stopped_reg;
        n_v          = 2'd0;
        found        = 1'b0;
        c            = (body_byte == fud_pkg::CHAR_PLUS) ? fud_pkg::CHAR_SPACE
                                                         : body_byte;
        v            = fud_pkg::escape_value(first_reg, c);
        act_lim      = '0;
        for (int i = 0; i < 3; i++)
            res_v[i] = '{kind: fud_pkg::KIND_END, sel: 2'd0, data: 8'd0, last: 1'b0};

        if (stopped_reg)
        begin
            // Ignore bytes after a zero byte until the body ends
            if (body_last)
            begin
                stopped_next = 1'b0;
                tok_pos_next = '0;
                cand_next    = 3'b111;
                act_next     = fud_pkg::NO_FIELD;
                raw_next     = '0;
                pct_next     = fud_pkg::PCT_IDLE;
                first_next   = 8'd0;
                closed_next  = 1'b0;
            end
        end
        else
        begin
            if (body_byte == fud_pkg::CHAR_NUL || body_byte == fud_pkg::CHAR_AMP)
            begin
                // Token ends: flush a short escape, close the value; a zero byte also ends the body
                if (act_next != fud_pkg::NO_FIELD && !closed_next
                    && pct_next != fud_pkg::PCT_IDLE)
                begin
                    res_v[n_v] = '{kind: fud_pkg::KIND_BYTE, sel: act_next,
                                   data: fud_pkg::CHAR_PERCENT, last: 1'b0};
                    n_v = n_v + 2'd1;
                    if (pct_next == fud_pkg::PCT_TWO)
                    begin
                        res_v[n_v] = '{kind: fud_pkg::KIND_BYTE, sel: act_next,
                                       data: first_next, last: 1'b0};
                        n_v = n_v + 2'd1;
                    end
                end
                if (body_byte == fud_pkg::CHAR_NUL)
                begin
                    res_v[n_v] = '{kind: fud_pkg::KIND_END, sel: 2'd0,
                                   data: 8'd0, last: 1'b0};
                    n_v = n_v + 2'd1;
                    stopped_next = !body_last;
                end
                tok_pos_next = '0;
                cand_next    = 3'b111;
                act_next     = fud_pkg::NO_FIELD;
                raw_next     = '0;
                pct_next     = fud_pkg::PCT_IDLE;
                first_next   = 8'd0;
                closed_next  = 1'b0;
            end
            else if (act_reg != fud_pkg::NO_FIELD)
            begin
                // Value character
                if (!closed_reg)
                begin
                    raw_next = raw_reg + CNT_W'(1);
                    unique case (pct_reg)
                        fud_pkg::PCT_IDLE:
                        begin
                            if (body_byte == fud_pkg::CHAR_PERCENT)
                                pct_next = fud_pkg::PCT_ONE;
                            else
                            begin
                                res_v[n_v] = '{kind: fud_pkg::KIND_BYTE, sel: act_reg,
                                               data: c, last: 1'b0};
                                n_v = n_v + 2'd1;
                            end
                        end
                        fud_pkg::PCT_ONE:
                        begin
                            first_next = c;
                            pct_next   = fud_pkg::PCT_TWO;
                        end
                        default:
                        begin
                            pct_next = fud_pkg::PCT_IDLE;
                            if (v == 8'd0)
                                closed_next = 1'b1;
                            else
                            begin
                                res_v[n_v] = '{kind: fud_pkg::KIND_BYTE, sel: act_reg,
                                               data: v, last: 1'b0};
                                n_v = n_v + 2'd1;
                            end
                        end
                    endcase
                    unique case (act_reg)
                        fud_pkg::FIELD_SSID:     act_lim = lim[0];
                        fud_pkg::FIELD_PASSWORD: act_lim = lim[1];
                        default:                 act_lim = lim[2];
                    endcase
                    // Limit reached: flush a short escape, close
                    if (!closed_next && LIM_W'(raw_next) >= act_lim)
                    begin
                        if (pct_next != fud_pkg::PCT_IDLE)
                        begin
                            res_v[n_v] = '{kind: fud_pkg::KIND_BYTE, sel: act_reg,
                                           data: fud_pkg::CHAR_PERCENT, last: 1'b0};
                            n_v = n_v + 2'd1;
                            if (pct_next == fud_pkg::PCT_TWO)
                            begin
                                res_v[n_v] = '{kind: fud_pkg::KIND_BYTE, sel: act_reg,
                                               data: first_next, last: 1'b0};
                                n_v = n_v + 2'd1;
                            end
                        end
                        pct_next    = fud_pkg::PCT_IDLE;
                        closed_next = 1'b1;
                    end
                end
            end
            else if (cand_reg != 3'b000)
            begin
                // Key matching against the three field names
                for (int k = 0; k < 3; k++)
                begin
                    if (cand_reg[k] && (tok_pos_reg >= fud_pkg::KEY_LEN[k]
                        || fud_pkg::KEY_TEXT[k][tok_pos_reg] != body_byte))
                        cand_next[k] = 1'b0;
                end
                if (tok_pos_reg != 4'd15)
                    tok_pos_next = tok_pos_reg + 4'd1;
                for (int k = 0; k < 3; k++)
                begin
                    if (!found && cand_next[k] && fud_pkg::KEY_LEN[k] == tok_pos_next)
                    begin
                        found       = 1'b1;
                        act_next    = 2'(k);
                        raw_next    = '0;
                        pct_next    = fud_pkg::PCT_IDLE;
                        closed_next = (lim[k] == '0);
                        res_v[n_v]  = '{kind: fud_pkg::KIND_START, sel: 2'(k),
                                        data: 8'd0, last: 1'b0};
                        n_v = n_v + 2'd1;
                    end
                end
            end

            // End of body after a nonzero byte
            if (body_last && body_byte != fud_pkg::CHAR_NUL)
            begin
                if (act_next != fud_pkg::NO_FIELD && !closed_next
                    && pct_next != fud_pkg::PCT_IDLE)
                begin
                    res_v[n_v] = '{kind: fud_pkg::KIND_BYTE, sel: act_next,
                                   data: fud_pkg::CHAR_PERCENT, last: 1'b0};
                    n_v = n_v + 2'd1;
                    if (pct_next == fud_pkg::PCT_TWO && n_v != 2'd3)
                    begin
                        res_v[n_v] = '{kind: fud_pkg::KIND_BYTE, sel: act_next,
                                       data: first_next, last: 1'b0};
                        n_v = n_v + 2'd1;
                    end
                end
                if (n_v != 2'd3)
                begin
                    res_v[n_v] = '{kind: fud_pkg::KIND_END, sel: 2'd0,
                                   data: 8'd0, last: 1'b0};
                    n_v = n_v + 2'd1;
                end
                tok_pos_next = '0;
                cand_next    = 3'b111;
                act_next     = fud_pkg::NO_FIELD;
                raw_next     = '0;
                pct_next     = fud_pkg::PCT_IDLE;
                first_next   = 8'd0;
                closed_next  = 1'b0;
            end
        end
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_pos_reg <= '0;
            cand_reg    <= 3'b111;
            act_reg     <= fud_pkg::NO_FIELD;
            raw_reg     <= '0;
            pct_reg     <= fud_pkg::PCT_IDLE;
            first_reg   <= 8'd0;
            closed_reg  <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else if (body_acc)
        begin
            tok_pos_reg <= tok_pos_next;
            cand_reg    <= cand_next;
            act_reg     <= act_next;
            raw_reg     <= raw_next;
            pct_reg     <= pct_next;
            first_reg   <= first_next;
            closed_reg  <= closed_next;
            stopped_reg <= stopped_next;
        end
    end

    // Result queue storage
    always_ff @(posedge clk)
    begin
        if (body_acc)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < n_v)
                begin
                    q_reg[wr_ptr_reg + QP_W'(i)] <= '{kind: res_v[i].kind,
                                                      sel:  res_v[i].sel,
                                                      data: res_v[i].data,
                                                      last: (2'(i) == n_v - 2'd1)};
                end
            end
        end
    end

    // Result queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (body_acc)
                wr_ptr_reg <= wr_ptr_reg + QP_W'(n_v);
            if (res_acc)
                rd_ptr_reg <= rd_ptr_reg + QP_W'(1);
            cnt_reg <= cnt_reg + (body_acc ? QC_W'(n_v) : QC_W'(0))
                               - (res_acc ? QC_W'(1) : QC_W'(0));
        end
    end

endmodule

// ----- bench/tb_form_urlencoded_field_decoder_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for form_urlencoded_field_decoder_core: directed and
// random form bodies, with a field decoder model predicting every result.
// Depends on fud_pkg and the core.
module tb_form_urlencoded_field_decoder_core;

    localparam int         CLK_PERIOD     = 10;
    localparam int         VALUE_CAP      = 256;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         IDLE_PCT       = 38;
    localparam int         PHASE_ITEMS    = 35;
    localparam logic [1:0] REG_UNUSED     = 2'd3;

    // DUT signals
    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       body_valid = 1'b0;
    logic       body_stall;
    logic [7:0] body_byte  = 8'd0;
    logic       body_last  = 1'b0;
    logic       res_valid;
    logic       res_stall  = 1'b0;
    logic [1:0] kind;
    logic [1:0] field_sel;
    logic [7:0] data_byte;
    logic       run_last;
    logic       cfg_wr_en  = 1'b0;
    logic [1:0] cfg_index  = 2'd0;
    logic [8:0] cfg_data   = 9'd0;

    // Bench control
    bit         no_idle        = 1'b0;
    int         mismatch_count = 0;
    int         quiet_cycles   = 0;
    int         items_sent     = 0;
    logic [7:0] gen_bytes [$];
    string      key_names [0:2];
    string      hex_digits     = "0123456789abcdefABCDEF";

    // Decoder model state
    logic [8:0]         limit_reg [0:2];
    logic [3:0]         tok_pos;
    logic [2:0]         key_live;
    logic [1:0]         open_field;
    logic [8:0]         raw_cnt;
    logic [1:0]         esc_phase;
    logic [7:0]         esc_first;
    logic               value_done;
    logic               body_halted;
    fud_pkg::result_t   step_results [0:2];
    int                 step_count;
    fud_pkg::result_t   expected_results [$];

    form_urlencoded_field_decoder_core #(
        .VALUE_LEN_MAX (VALUE_CAP)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .body_valid (body_valid),
        .body_stall (body_stall),
        .body_byte  (body_byte),
        .body_last  (body_last),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .kind       (kind),
        .field_sel  (field_sel),
        .data_byte  (data_byte),
        .run_last   (run_last),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // -1 when not a hex digit
    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    // Base-16 parse of an escape pair: one leading blank skipped, minus sign allowed
    function automatic logic [7:0] decode_pair(input logic [7:0] c1, input logic [7:0] c2);
        int hi;
        int lo;
        hi = nibble_of(c1);
        lo = nibble_of(c2);
        if (c1 == fud_pkg::CHAR_SPACE || (c1 >= 8'h09 && c1 <= 8'h0D))
            return (lo < 0) ? 8'd0 : 8'(lo);
        if (c1 == fud_pkg::CHAR_MINUS)
            return (lo < 0) ? 8'd0 : 8'(256 - lo);
        if (hi < 0)
            return 8'd0;
        if (lo < 0)
            return 8'(hi);
        return 8'(hi * 16 + lo);
    endfunction

    // Effective raw length limit of a field
    function automatic int field_cap(input logic [1:0] f);
        return (int'(limit_reg[f]) > VALUE_CAP) ? VALUE_CAP : int'(limit_reg[f]);
    endfunction

    // At most three results per body byte
    function automatic void add_result(input fud_pkg::res_kind_t k, input logic [1:0] f,
                                       input logic [7:0] d);
        if (step_count < 3)
        begin
            step_results[step_count] = '{kind: k, sel: f, data: d, last: 1'b0};
            step_count++;
        end
    endfunction

    function automatic void clear_token();
        tok_pos    = 4'd0;
        key_live   = 3'b111;
        open_field = fud_pkg::NO_FIELD;
        raw_cnt    = 9'd0;
        esc_phase  = fud_pkg::PCT_IDLE;
        esc_first  = 8'd0;
        value_done = 1'b0;
    endfunction

    // A pending escape is flushed literally when its value ends
    function automatic void close_open_value();
        if (open_field != fud_pkg::NO_FIELD && !value_done && esc_phase != fud_pkg::PCT_IDLE)
        begin
            add_result(fud_pkg::KIND_BYTE, open_field, fud_pkg::CHAR_PERCENT);
            if (esc_phase == fud_pkg::PCT_TWO)
                add_result(fud_pkg::KIND_BYTE, open_field, esc_first);
        end
        esc_phase  = fud_pkg::PCT_IDLE;
        value_done = 1'b1;
    endfunction

    function automatic void take_value_char(input logic [7:0] b);
        logic [7:0] ch;
        logic [7:0] val;
        ch = (b == fud_pkg::CHAR_PLUS) ? fud_pkg::CHAR_SPACE : b;
        raw_cnt++;
        unique case (esc_phase)
            fud_pkg::PCT_IDLE:
                if (b == fud_pkg::CHAR_PERCENT)
                    esc_phase = fud_pkg::PCT_ONE;
                else
                    add_result(fud_pkg::KIND_BYTE, open_field, ch);
            fud_pkg::PCT_ONE:
            begin
                esc_first = ch;
                esc_phase = fud_pkg::PCT_TWO;
            end
            default:
            begin
                val       = decode_pair(esc_first, ch);
                esc_phase = fud_pkg::PCT_IDLE;
                // decoded zero ends the value silently
                if (val == 8'd0)
                    value_done = 1'b1;
                else
                    add_result(fud_pkg::KIND_BYTE, open_field, val);
            end
        endcase
        if (!value_done && int'(raw_cnt) >= field_cap(open_field))
            close_open_value();
    endfunction

    // Key match, narrowing the live candidates one character at a time
    function automatic void take_key_char(input logic [7:0] b);
        bit opened;
        opened = 1'b0;
        if (key_live == 3'b000)
            return;
        for (int k = 0; k < 3; k++)
            if (key_live[k] && (int'(tok_pos) >= key_names[k].len() ||
                                key_names[k][tok_pos] != b))
                key_live[k] = 1'b0;
        if (tok_pos < 4'd15)
            tok_pos++;
        for (int k = 0; k < 3; k++)
        begin
            if (!opened && key_live[k] && key_names[k].len() == int'(tok_pos))
            begin
                opened     = 1'b1;
                open_field = 2'(k);
                raw_cnt    = 9'd0;
                esc_phase  = fud_pkg::PCT_IDLE;
                value_done = (field_cap(2'(k)) == 0);
                add_result(fud_pkg::KIND_START, 2'(k), 8'd0);
            end
        end
    endfunction

    // Work out the results of one accepted body byte and queue them
    function automatic void predict_byte(input logic [7:0] b, input logic last);
        step_count = 0;
        if (body_halted)
        begin
            if (last)
            begin
                body_halted = 1'b0;
                clear_token();
            end
        end
        else if (b == fud_pkg::CHAR_NUL)
        begin
            close_open_value();
            add_result(fud_pkg::KIND_END, fud_pkg::FIELD_SSID, 8'd0);
            clear_token();
            body_halted = !last;
        end
        else
        begin
            if (b == fud_pkg::CHAR_AMP)
            begin
                close_open_value();
                clear_token();
            end
            else if (open_field != fud_pkg::NO_FIELD)
            begin
                if (!value_done)
                    take_value_char(b);
            end
            else
                take_key_char(b);
            if (last)
            begin
                close_open_value();
                add_result(fud_pkg::KIND_END, fud_pkg::FIELD_SSID, 8'd0);
                clear_token();
            end
        end
        for (int i = 0; i < step_count; i++)
        begin
            step_results[i].last = (i == step_count - 1);
            expected_results.push_back(step_results[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Result requests: compare with the oldest expectation, then draw the next stall
    always @(posedge clk)
    begin : check_results
        fud_pkg::result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf(
                    "unexpected result kind=%0d sel=%0d data=%02h last=%0b",
                    kind, field_sel, data_byte, run_last));
            else
            begin
                want = expected_results.pop_front();
                if (kind !== want.kind || field_sel !== want.sel ||
                    data_byte !== want.data || run_last !== want.last)
                    report_mismatch($sformatf(
                        "got kind=%0d sel=%0d data=%02h last=%0b, want %0d %0d %02h %0b",
                        kind, field_sel, data_byte, run_last,
                        want.kind, want.sel, want.data, want.last));
            end
        end
        res_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end

    // Watchdog: cycles with no request accepted on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((body_valid && !body_stall) || (res_valid && !res_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_form_urlencoded_field_decoder_core: FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------

    // One body request; valid stays high on return so the next byte can follow at once
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            body_valid <= 1'b0;
            @(posedge clk);
        end
        body_valid <= 1'b1;
        body_byte  <= b;
        body_last  <= last;
        @(posedge clk);
        while (body_stall)
            @(posedge clk);
        predict_byte(b, last);
        items_sent++;
    endtask

    task automatic send_text(input string s, input bit mark_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], mark_last && (i == s.len() - 1));
    endtask

    // Sender holds off until every expected result is in, plus a settle time
    task automatic wait_results_drained();
        body_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (idx <= fud_pkg::REG_URL_LEN)
            limit_reg[idx] = val;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            gen_bytes.push_back(s[i]);
    endtask

    // Random body: mostly keyed tokens with mixed value content, some noise
    task automatic build_body();
        int         n_tok;
        int         r;
        int         vlen;
        int         pos;
        string      key;
        logic [7:0] lead;
        gen_bytes.delete();
        if ($urandom_range(29) == 0)
        begin
            gen_bytes.push_back(fud_pkg::CHAR_NUL);
            return;
        end
        n_tok = $urandom_range(1, 4);
        for (int t = 0; t < n_tok; t++)
        begin
            if (t != 0)
                gen_bytes.push_back(fud_pkg::CHAR_AMP);
            r = $urandom_range(99);
            if (r < 75)
            begin
                push_text(key_names[$urandom_range(2)]);
                vlen = ($urandom_range(7) == 0) ? $urandom_range(24) : $urandom_range(6);
                for (int i = 0; i < vlen; i++)
                begin
                    case ($urandom_range(9))
                        0, 1, 2, 3: gen_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
                        4:          gen_bytes.push_back(fud_pkg::CHAR_PLUS);
                        5:          gen_bytes.push_back(fud_pkg::CHAR_PERCENT);
                        6, 7, 8:
                        begin
                            gen_bytes.push_back(fud_pkg::CHAR_PERCENT);
                            case ($urandom_range(7))
                                0:       lead = fud_pkg::CHAR_SPACE;
                                1:       lead = fud_pkg::CHAR_MINUS;
                                2:       lead = fud_pkg::CHAR_PLUS;
                                3:       lead = 8'($urandom_range(9, 13));
                                4:       lead = "0";
                                5:       lead = "g";
                                default: lead = hex_digits[$urandom_range(21)];
                            endcase
                            gen_bytes.push_back(lead);
                            case ($urandom_range(4))
                                0:       gen_bytes.push_back(8'($urandom_range(1, 255)));
                                1:       gen_bytes.push_back("0");
                                default: gen_bytes.push_back(hex_digits[$urandom_range(21)]);
                            endcase
                        end
                        default:    gen_bytes.push_back(8'($urandom_range(1, 255)));
                    endcase
                end
            end
            else if (r < 90)
            begin
                // near-miss key: one character changed, maybe cut short
                key      = key_names[$urandom_range(2)];
                pos      = $urandom_range(key.len() - 1);
                key[pos] = 8'($urandom_range(1, 255));
                if ($urandom_range(1) == 0)
                    key = key.substr(0, pos);
                push_text(key);
                gen_bytes.push_back("v");
            end
            else
            begin
                // raw noise, long enough at times to run the key position out
                vlen = $urandom_range(1, 20);
                for (int i = 0; i < vlen; i++)
                    gen_bytes.push_back(8'($urandom_range(1, 255)));
            end
        end
        if ($urandom_range(14) == 0)
            gen_bytes.insert($urandom_range(gen_bytes.size() - 1), fud_pkg::CHAR_NUL);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_cases();
        write_reg(fud_pkg::REG_NAME_LEN, 9'd3);
        write_reg(fud_pkg::REG_PASSWORD_LEN, 9'd0);
        write_reg(fud_pkg::REG_URL_LEN, 9'h1FF);
        write_reg(REG_UNUSED, 9'h1FF);
        // plus becomes space; escape cut short by the limit comes out literally
        send_text("ssid=+%-&", 1'b0);
        // zero byte mid-escape ends the body; bytes are dropped up to and including the last one
        send_text("ssid=%0", 1'b0);
        send_byte(fud_pkg::CHAR_NUL, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte("x", 1'b1);
        // decoded zero closes the value; zero byte that is also the last byte
        send_text("ssid=%00", 1'b0);
        send_byte(fud_pkg::CHAR_NUL, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_random_bodies(input logic [8:0] name_lim, input logic [8:0] pw_len,
                                      input logic [8:0] url_len, input bit calm);
        int first_item;
        write_reg(fud_pkg::REG_NAME_LEN, name_lim);
        write_reg(fud_pkg::REG_PASSWORD_LEN, pw_len);
        write_reg(fud_pkg::REG_URL_LEN, url_len);
        no_idle    = calm;
        first_item = items_sent;
        while (items_sent - first_item < PHASE_ITEMS)
        begin
            build_body();
            foreach (gen_bytes[i])
                send_byte(gen_bytes[i], i == gen_bytes.size() - 1);
            if ($urandom_range(9) == 0)
                wait_results_drained();
        end
        wait_results_drained();
        no_idle = 1'b0;
    endtask

    initial
    begin
        key_names[0] = "ssid=";
        key_names[1] = "password=";
        key_names[2] = {"image_", "url="};
        limit_reg[fud_pkg::REG_NAME_LEN]     = fud_pkg::NAME_LEN_RST;
        limit_reg[fud_pkg::REG_PASSWORD_LEN] = fud_pkg::PASS_LEN_RST;
        limit_reg[fud_pkg::REG_URL_LEN]      = fud_pkg::URL_LEN_RST;
        clear_token();
        body_halted = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_bodies(9'($urandom_range(1, 8)), 9'd0, 9'($urandom_range(1, 8)), 1'b1);
        test_random_bodies(9'd1, 9'd1, 9'd1, 1'b0);
        test_random_bodies(9'd256, 9'($urandom_range(1, 511)), 9'($urandom_range(2, 12)), 1'b0);
        test_random_bodies(9'($urandom_range(0, 511)), 9'($urandom_range(1, 6)), 9'd256, 1'b0);
        wait_results_drained();

        if (mismatch_count == 0)
            $display("tb_form_urlencoded_field_decoder_core: PASS");
        else
            $display("tb_form_urlencoded_field_decoder_core: FAIL");
        $finish;
    end

endmodule
